// ===== rtl/lsv_pkg.sv =====
`timescale 1ns / 1ps
package lsv_pkg;

  localparam int unsigned SAMPLE_MEM_DEPTH = 524288;
  localparam int unsigned MEM_AW = $clog2(SAMPLE_MEM_DEPTH);

  localparam int unsigned FRAC_BITS  = 12;
  localparam int unsigned OUT_RATE   = 48000;
  localparam int unsigned MIX_SHIFT  = 11;
  localparam int unsigned PAN_CENTER = 32;

  localparam int unsigned LOOP_W = 19;
  localparam int unsigned PITCH_W = 20;
  localparam int unsigned GAIN_W = 13;
  localparam int unsigned PAN_W = 7;
  localparam int unsigned POS_W = 31;
  localparam int unsigned CFG_DATA_W = 20;

  typedef logic [1:0]           mode_t;
  typedef logic [LOOP_W-1:0]    addr_t;
  typedef logic signed [7:0]    sample_t;
  typedef logic signed [14:0]   mix_t;
  typedef logic [2:0]           cfg_addr_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [MEM_AW-1:0]    mem_addr_t;

  localparam mode_t MODE_WRITE   = 2'd0;
  localparam mode_t MODE_RESTART = 2'd1;
  localparam mode_t MODE_RENDER  = 2'd2;
  localparam mode_t MODE_NONE    = 2'd3;

  localparam cfg_addr_t REG_LOOP_BEGIN = 3'd0;
  localparam cfg_addr_t REG_LOOP_SPAN  = 3'd1;
  localparam cfg_addr_t REG_PITCH_HZ   = 3'd2;
  localparam cfg_addr_t REG_GAIN       = 3'd3;
  localparam cfg_addr_t REG_PAN        = 3'd4;

  // depth is a power of two: the index wraps by keeping the low bits
  function automatic mem_addr_t mem_index(addr_t a);
    logic [MEM_AW+LOOP_W-1:0] ext;
    ext = {{MEM_AW{1'b0}}, a};
    return ext[MEM_AW-1:0];
  endfunction

endpackage

// ===== rtl/lsv_in_if.sv =====
`timescale 1ns / 1ps
interface lsv_in_if;
  import lsv_pkg::*;
  logic    valid;
  logic    ready;
  mode_t   mode;
  addr_t   addr;
  sample_t sample_byte;
  modport source (output valid, mode, addr, sample_byte, input ready);
  modport sink (input valid, mode, addr, sample_byte, output ready);
endinterface

// ===== rtl/lsv_out_if.sv =====
`timescale 1ns / 1ps
interface lsv_out_if;
  import lsv_pkg::*;
  logic valid;
  logic ready;
  mix_t left_out;
  mix_t right_out;
  logic playing;
  modport source (output valid, left_out, right_out, playing, input ready);
  modport sink (input valid, left_out, right_out, playing, output ready);
endinterface

// ===== rtl/looped_sample_voice.sv =====
`timescale 1ns / 1ps
// Sequence: write and restart finish on the transfer; a zero-gain render goes straight to the
// output push, a stopped voice after the position check, a playing frame after the read,
// multiply and step states, after the loop modulo if the position wraps (19-step radix-2
// divider, four passes through one shared multiplier, reciprocal multiply for pitch step).
// Throughput: one item at a time; ready is high only while the sequencer is idle.
// Reset: sequencer, output valid, registers and position clear; sample memory is undefined.
module looped_sample_voice (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  lsv_pkg::cfg_addr_t cfg_addr_i,
  input  lsv_pkg::cfg_data_t cfg_wdata_i,
  lsv_in_if.sink            in_i,
  lsv_out_if.source         out_o
);
  import lsv_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_READ  = 4'd3;
  localparam logic [3:0] S_MULR  = 4'd4;
  localparam logic [3:0] S_MULSL = 4'd5;
  localparam logic [3:0] S_MULSR = 4'd6;
  localparam logic [3:0] S_STEP  = 4'd7;
  localparam logic [3:0] S_PUSH  = 4'd8;

  localparam logic [5:0] MOD_STEPS = 6'(LOOP_W);
  localparam logic signed [13:0] PAN_C = 14'(PAN_CENTER);
  // step = pitch * 4096 / 48000, as a multiply by the rounded-up reciprocal
  localparam int unsigned STEP_SHIFT = 29;
  localparam logic [25:0] STEP_RECIP =
    26'(((64'd1 << (FRAC_BITS + STEP_SHIFT)) + 64'(OUT_RATE) - 64'd1) / 64'(OUT_RATE));

  logic [3:0] state_q, state_d;
  logic [LOOP_W-1:0] lbeg_q, lbeg_d, lspan_q, lspan_d;
  logic [PITCH_W-1:0] pitch_q, pitch_d;
  logic [GAIN_W-1:0] gain_q, gain_d;
  logic signed [PAN_W-1:0] pan_q, pan_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [5:0] cnt_q, cnt_d;
  logic [LOOP_W-1:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [31:0] quo_q, quo_d;
  logic signed [21:0] lamp_q, lamp_d, ramp_q, ramp_d;
  mix_t res_left_q, res_left_d, res_right_q, res_right_d;
  logic res_play_q, res_play_d;
  logic out_valid_q, out_valid_d;
  mix_t out_left_q, out_left_d, out_right_q, out_right_d;
  logic out_play_q, out_play_d;

  logic in_xfer;
  logic [LOOP_W:0] trial;
  logic ge;
  logic [LOOP_W-1:0] rem_nx;
  logic [LOOP_W:0] lend_w;
  logic pos_ge;
  logic signed [21:0] mul_a;
  logic signed [13:0] mul_b, pan_ext;
  logic signed [35:0] mul_p, mul_sh;
  mix_t mul_sat;
  logic [PITCH_W+25:0] step_prod;
  sample_t smp;
  logic [7:0] ram_rdata;
  logic ram_re;
  mem_addr_t ram_addr;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer = in_i.valid && in_i.ready;

  // restoring divider step for the loop modulo
  assign trial  = {rem_q, quo_q[31]};
  assign ge     = trial >= {1'b0, dvs_q};
  assign rem_nx = ge ? LOOP_W'(trial - {1'b0, dvs_q}) : trial[LOOP_W-1:0];

  assign lend_w = (LOOP_W+1)'(lbeg_q) + (LOOP_W+1)'(lspan_q);
  assign pos_ge = {1'b0, pos_q} >= {lend_w, FRAC_BITS'(0)};

  assign smp = sample_t'(ram_rdata);
  assign pan_ext = 14'(pan_q);

  assign step_prod = pitch_q * STEP_RECIP;

  // shared multiplier
  always_comb begin
    unique case (state_q)
      S_READ: begin
        mul_a = $signed(22'(gain_q));
        mul_b = PAN_C - pan_ext;
      end
      S_MULR: begin
        mul_a = $signed(22'(gain_q));
        mul_b = PAN_C + pan_ext;
      end
      S_MULSL: begin
        mul_a = lamp_q;
        mul_b = 14'(smp);
      end
      default: begin
        mul_a = ramp_q;
        mul_b = 14'(smp);
      end
    endcase
  end

  assign mul_p  = mul_a * mul_b;
  assign mul_sh = mul_p >>> MIX_SHIFT;

  always_comb begin
    priority if (mul_sh > 36'sd16383) begin
      mul_sat = 15'sh3FFF;
    end else if (mul_sh < -36'sd16384) begin
      mul_sat = 15'sh4000;
    end else begin
      mul_sat = mul_sh[14:0];
    end
  end

  always_comb begin
    state_d = state_q;
    lbeg_d = lbeg_q;
    lspan_d = lspan_q;
    pitch_d = pitch_q;
    gain_d = gain_q;
    pan_d = pan_q;
    pos_d = pos_q;
    cnt_d = cnt_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    quo_d = quo_q;
    lamp_d = lamp_q;
    ramp_d = ramp_q;
    res_left_d = res_left_q;
    res_right_d = res_right_q;
    res_play_d = res_play_q;
    out_valid_d = out_valid_q;
    out_left_d = out_left_q;
    out_right_d = out_right_q;
    out_play_d = out_play_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_LOOP_BEGIN: lbeg_d = cfg_wdata_i[LOOP_W-1:0];
        REG_LOOP_SPAN:  lspan_d = cfg_wdata_i[LOOP_W-1:0];
        REG_PITCH_HZ:   pitch_d = cfg_wdata_i[PITCH_W-1:0];
        REG_GAIN:       gain_d = cfg_wdata_i[GAIN_W-1:0];
        REG_PAN:        pan_d = $signed(cfg_wdata_i[PAN_W-1:0]);
        default: begin
        end
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_i.mode)
            MODE_WRITE: begin
            end
            MODE_RESTART: pos_d = {in_i.addr, FRAC_BITS'(0)};
            MODE_RENDER: begin
              res_left_d = '0;
              res_right_d = '0;
              res_play_d = 1'b0;
              state_d = (gain_q == '0) ? S_PUSH : S_CHECK;
            end
            MODE_NONE: begin
            end
          endcase
        end
      end
      S_CHECK: begin
        if (!pos_ge) begin
          state_d = S_READ;
        end else if (lspan_q > LOOP_W'(1)) begin
          quo_d = {pos_q[POS_W-1:FRAC_BITS] - lbeg_q, 13'b0};
          rem_d = '0;
          dvs_d = lspan_q;
          cnt_d = MOD_STEPS;
          state_d = S_MOD;
        end else begin
          pos_d = {lend_w[LOOP_W-1:0], FRAC_BITS'(0)};
          state_d = S_PUSH;
        end
      end
      S_MOD: begin
        if (cnt_q != '0) begin
          rem_d = rem_nx;
          quo_d = {quo_q[30:0], ge};
          cnt_d = cnt_q - 6'd1;
        end else begin
          pos_d = {LOOP_W'(lbeg_q + rem_q), pos_q[FRAC_BITS-1:0]};
          state_d = S_READ;
        end
      end
      S_READ: begin
        lamp_d = mul_p[21:0];
        state_d = S_MULR;
      end
      S_MULR: begin
        ramp_d = mul_p[21:0];
        state_d = S_MULSL;
      end
      S_MULSL: begin
        res_left_d = mul_sat;
        state_d = S_MULSR;
      end
      S_MULSR: begin
        res_right_d = mul_sat;
        res_play_d = 1'b1;
        quo_d = 32'(step_prod[PITCH_W+25:STEP_SHIFT]);
        state_d = S_STEP;
      end
      S_STEP: begin
        pos_d = POS_W'({1'b0, pos_q} + quo_q);
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_left_d = res_left_q;
          out_right_d = res_right_q;
          out_play_d = res_play_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lbeg_q <= '0;
      lspan_q <= '0;
      pitch_q <= '0;
      gain_q <= '0;
      pan_q <= '0;
      pos_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lbeg_q <= lbeg_d;
      lspan_q <= lspan_d;
      pitch_q <= pitch_d;
      gain_q <= gain_d;
      pan_q <= pan_d;
      pos_q <= pos_d;
      cnt_q <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    lamp_q <= lamp_d;
    ramp_q <= ramp_d;
    res_left_q <= res_left_d;
    res_right_q <= res_right_d;
    res_play_q <= res_play_d;
    out_left_q <= out_left_d;
    out_right_q <= out_right_d;
    out_play_q <= out_play_d;
  end

  assign ram_re   = (state_q == S_READ);
  assign ram_addr = ram_re ? mem_index(pos_q[POS_W-1:FRAC_BITS]) : mem_index(in_i.addr);

  lsv_ram #(
    .WIDTH(8),
    .DEPTH(SAMPLE_MEM_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (in_xfer && (in_i.mode == MODE_WRITE)),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(in_i.sample_byte),
    .rdata_o(ram_rdata)
  );

  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = out_left_q;
  assign out_o.right_out = out_right_q;
  assign out_o.playing   = out_play_q;

  a_silent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.playing |-> out_o.left_out == '0 && out_o.right_out == '0)
    else $error("silent frame with nonzero output");

  a_render_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_i.mode == MODE_RENDER |=> state_q != S_IDLE)
    else $error("render transfer did not start sequencer");

  a_mod_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOD |-> dvs_q > LOOP_W'(1))
    else $error("loop modulo with span of one or less");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_STEP |-> quo_q[31:PITCH_W+26-STEP_SHIFT] == '0)
    else $error("pitch step out of range");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MOD |-> cnt_q <= MOD_STEPS)
    else $error("loop modulo step count out of range");
endmodule

// ===== rtl/lsv_ram.sv =====
`timescale 1ns / 1ps
module lsv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
